@@ design/cef_pkg.sv @@
package cef_pkg;

  // Store geometry.
  localparam int MAX_POINTS = 128;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int COORD_W    = 32;
  localparam int RAD_W      = 31;
  localparam int WORD_W     = 2 * COORD_W;

  // One input item: a point and the end-of-set mark.
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic fits;
    logic overflowed;
  } out_item_t;

  // Start of an evaluation, from the load side to the search sequencer.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } eval_req_t;

  // End of an evaluation.
  typedef struct packed {
    logic done;
    logic fits;
  } eval_rsp_t;

  // Request to the root unit: isqrt(floor(a*b/c)).
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } root_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } root_rsp_t;

  typedef enum logic [1:0] {
    TS_LOAD,
    TS_EVAL,
    TS_HOLD
  } top_state_t;

  typedef enum logic [2:0] {
    RU_IDLE,
    RU_MUL,
    RU_DIV,
    RU_SQRT,
    RU_DONE
  } root_state_t;

  typedef enum logic [4:0] {
    SS_IDLE,
    SS_LIM,
    SS_LIMW,
    SS_SAME_RD,
    SS_SAME_CHK,
    SS_PI_RD,
    SS_PJ_RD,
    SS_PJ_CAP,
    SS_DIFF,
    SS_SQX,
    SS_SQY,
    SS_D2,
    SS_CHK,
    SS_ROOT_GO,
    SS_ROOT_WAIT,
    SS_CENTRE,
    SS_T_RD,
    SS_T_CHK,
    SS_T_MX,
    SS_T_MY,
    SS_T_SUM,
    SS_DONE
  } srch_state_t;

endpackage

@@ design/circle_enclosure_feasibility_top.sv @@
// Channel | Ports                          | Moves
// input   | in_valid, in_ready, in_data    | one point per item, last_point closes the set
// output  | out_valid, out_ready, out_data | fits and overflowed, one item per set
// config  | cfg_we, cfg_wdata              | radius, unsigned Q15.16
//
// Points load one item per cycle into the point memory while input is ready.
// After the last point, input stalls while the pair search runs: two root-unit
// passes per pair, then a test of every other point against each centre tried.
// The result sits in an output register; points of the next set load while it waits.
// Reset is synchronous and clears the count, overflow flag, radius and handshakes.
module circle_enclosure_feasibility_top import cef_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [RAD_W-1:0] cfg_wdata
);

  top_state_t       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt, ovfh_r, ovfh_nxt, fitsh_r, fitsh_nxt;
  logic [RAD_W-1:0] radius_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             acc, full, wr_en, slot_free;
  eval_req_t        ereq;
  eval_rsp_t        ersp;
  root_req_t        rreq;
  root_rsp_t        rrsp;
  logic [IDX_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  assign in_ready  = (st_r == TS_LOAD);
  assign acc       = in_valid && in_ready;
  assign full      = (cnt_r == CNT_W'(MAX_POINTS));
  assign wr_en     = acc && !full;
  assign slot_free = !out_valid_r || out_ready;

  assign ereq.start = acc && in_data.last_point;
  assign ereq.count = full ? cnt_r : (cnt_r + 1'b1);

  // Load, evaluate and deliver.
  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    ovfh_nxt      = ovfh_r;
    fitsh_nxt     = fitsh_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (st_r)
      TS_LOAD: begin
        if (acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_data.last_point) begin
            ovfh_nxt = ovf_r || full;
            cnt_nxt  = '0;
            ovf_nxt  = 1'b0;
            st_nxt   = TS_EVAL;
          end
        end
      end
      TS_EVAL: begin
        if (ersp.done) begin
          if (slot_free) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.fits       = ersp.fits;
            out_data_nxt.overflowed = ovfh_r;
            st_nxt                  = TS_LOAD;
          end else begin
            fitsh_nxt = ersp.fits;
            st_nxt    = TS_HOLD;
          end
        end
      end
      TS_HOLD: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.fits       = fitsh_r;
          out_data_nxt.overflowed = ovfh_r;
          st_nxt                  = TS_LOAD;
        end
      end
      default: st_nxt = TS_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= TS_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      radius_r    <= '0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
    end
    ovfh_r     <= ovfh_nxt;
    fitsh_r    <= fitsh_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cef_store u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({in_data.point_x, in_data.point_y}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cef_root_unit u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rreq),
    .rsp   (rrsp)
  );

  cef_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .ereq    (ereq),
    .radius  (radius_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rreq    (rreq),
    .rrsp    (rrsp),
    .ersp    (ersp)
  );

endmodule

@@ design/cef_store.sv @@
module cef_store import cef_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [WORD_W-1:0] rdata
);

  // Point memory, one word of {x, y} per entry, registered read.
  logic [WORD_W-1:0] mem [MAX_POINTS];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/cef_root_unit.sv @@
module cef_root_unit import cef_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  root_req_t req,
  output root_rsp_t rsp
);

  root_state_t state_r, state_nxt;
  logic [2:0]   pp_r, pp_nxt;
  logic [6:0]   step_r, step_nxt;
  logic [63:0]  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [127:0] prod_r, prod_nxt;
  logic [63:0]  rem_r, rem_nxt;
  // Holds the quotient during division and the radicand during the root.
  logic [63:0]  quo_r, quo_nxt;
  logic [63:0]  res_r, res_nxt;
  logic [63:0]  bit_r, bit_nxt;
  logic [63:0]  mul_p_r;

  logic [31:0]  mul_a, mul_b;
  logic [6:0]   sh;
  logic [127:0] addend;
  logic [64:0]  t, diff;
  logic         ge;
  logic [63:0]  trial;

  // Partial product select: low/high halves of a and b.
  assign mul_a = pp_r[1] ? a_r[63:32] : a_r[31:0];
  assign mul_b = pp_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    unique case (pp_r)
      3'd2, 3'd3: sh = 7'd32;
      3'd4:       sh = 7'd64;
      default:    sh = 7'd0;
    endcase
  end

  assign addend = {64'b0, mul_p_r} << sh;
  assign t      = {rem_r, prod_r[127]};
  assign ge     = t >= {1'b0, c_r};
  assign diff   = t - {1'b0, c_r};
  assign trial  = res_r + bit_r;

  // Sequencer: four partial products, restoring division, bitwise root.
  always_comb begin
    state_nxt = state_r;
    pp_nxt    = pp_r;
    step_nxt  = step_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      RU_IDLE: begin
        if (req.start) begin
          a_nxt     = req.a;
          b_nxt     = req.b;
          c_nxt     = req.c;
          prod_nxt  = '0;
          pp_nxt    = '0;
          state_nxt = RU_MUL;
        end
      end
      RU_MUL: begin
        pp_nxt = pp_r + 3'd1;
        if (pp_r != 3'd0) begin
          prod_nxt = prod_r + addend;
        end
        if (pp_r == 3'd4) begin
          step_nxt  = '0;
          rem_nxt   = '0;
          quo_nxt   = '0;
          state_nxt = RU_DIV;
        end
      end
      RU_DIV: begin
        rem_nxt  = ge ? diff[63:0] : t[63:0];
        quo_nxt  = {quo_r[62:0], ge};
        prod_nxt = {prod_r[126:0], 1'b0};
        step_nxt = step_r + 7'd1;
        if (step_r == 7'd127) begin
          step_nxt  = '0;
          res_nxt   = '0;
          bit_nxt   = 64'd1 << 62;
          state_nxt = RU_SQRT;
        end
      end
      RU_SQRT: begin
        if (quo_r >= trial) begin
          quo_nxt = quo_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + 7'd1;
        if (step_r == 7'd31) begin
          state_nxt = RU_DONE;
        end
      end
      RU_DONE: begin
        state_nxt = RU_IDLE;
      end
      default: state_nxt = RU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pp_r    <= pp_nxt;
    step_r  <= step_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
    mul_p_r <= mul_a * mul_b;
  end

  assign rsp.done = (state_r == RU_DONE);
  assign rsp.root = res_r[31:0];

endmodule

@@ design/cef_search.sv @@
module cef_search import cef_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  eval_req_t         ereq,
  input  logic [RAD_W-1:0]  radius,
  output logic [IDX_W-1:0]  rd_addr,
  input  logic [WORD_W-1:0] rd_data,
  output root_req_t         rreq,
  input  root_rsp_t         rrsp,
  output eval_rsp_t         ersp
);

  srch_state_t state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic signed [COORD_W-1:0] xi_r, xi_nxt, yi_r, yi_nxt, xj_r, xj_nxt, yj_r, yj_nxt;
  logic [63:0] lim_r, lim_nxt;
  logic [31:0] adx_r, adx_nxt, ady_r, ady_nxt;
  logic        dyp_r, dyp_nxt, dxn_r, dxn_nxt;
  logic [32:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [63:0] dx2_r, dx2_nxt, dy2_r, dy2_nxt, d2_r, d2_nxt, q_r, q_nxt;
  logic        ph_r, ph_nxt, side_r, side_nxt, fits_r, fits_nxt;
  logic [31:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [31:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [63:0] ex2_r, ex2_nxt;
  logic [63:0] mul_p_r;

  logic [31:0] two_r, mul_a, mul_b;
  logic [32:0] dx, dy, adx, ady;
  logic [64:0] d2, s;
  logic [33:0] ox, oy;
  logic [35:0] ex_s, ey_s, exm, eym;
  logic signed [COORD_W-1:0] px, py;
  logic [CNT_W:0] j_inc, i_inc2, k_inc;
  logic wrap, last_pair, next_pair, k_adv, fail, skip;

  assign two_r = {radius, 1'b0};
  assign px    = rd_data[WORD_W-1:COORD_W];
  assign py    = rd_data[COORD_W-1:0];

  // Pair bookkeeping.
  assign j_inc     = {1'b0, j_r} + 1'b1;
  assign i_inc2    = {1'b0, i_r} + 2'd2;
  assign k_inc     = {1'b0, k_r} + 1'b1;
  assign wrap      = (j_inc == {1'b0, n_r});
  assign last_pair = wrap && (i_inc2 == {1'b0, n_r});

  // Pair differences and midpoint sums.
  assign dx  = {xi_r[31], xi_r} - {xj_r[31], xj_r};
  assign dy  = {yi_r[31], yi_r} - {yj_r[31], yj_r};
  assign adx = dx[32] ? (33'd0 - dx) : dx;
  assign ady = dy[32] ? (33'd0 - dy) : dy;
  assign d2  = {1'b0, dx2_r} + {1'b0, dy2_r};

  // Centre offsets; the second centre uses the negated pair.
  assign ox = (dyp_r ^ side_r) ? {2'b0, ax_r} : (34'd0 - {2'b0, ax_r});
  assign oy = (dxn_r ^ side_r) ? {2'b0, ay_r} : (34'd0 - {2'b0, ay_r});

  // Offset of a doubled point from the doubled centre.
  assign ex_s = {{3{px[31]}}, px, 1'b0} - {{2{cx_r[33]}}, cx_r};
  assign ey_s = {{3{py[31]}}, py, 1'b0} - {{2{cy_r[33]}}, cy_r};
  assign exm  = ex_s[35] ? (36'd0 - ex_s) : ex_s;
  assign eym  = ey_s[35] ? (36'd0 - ey_s) : ey_s;
  assign s    = {1'b0, ex2_r} + {1'b0, mul_p_r};

  assign skip = (k_r == i_r) || (k_r == j_r) ||
                ((px == xi_r) && (py == yi_r)) || ((px == xj_r) && (py == yj_r));

  // Shared 32x32 multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      SS_LIM:  begin mul_a = two_r; mul_b = two_r; end
      SS_SQX:  begin mul_a = adx_r; mul_b = adx_r; end
      SS_SQY:  begin mul_a = ady_r; mul_b = ady_r; end
      SS_T_MX: begin mul_a = ex_r;  mul_b = ex_r;  end
      SS_T_MY: begin mul_a = ey_r;  mul_b = ey_r;  end
      default: begin mul_a = '0;    mul_b = '0;    end
    endcase
  end

  // Read address for the point memory.
  always_comb begin
    unique case (state_r)
      SS_PI_RD: rd_addr = i_r[IDX_W-1:0];
      SS_PJ_RD: rd_addr = j_r[IDX_W-1:0];
      default:  rd_addr = k_r[IDX_W-1:0];
    endcase
  end

  // Search sequencer.
  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;  i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;
    xi_nxt = xi_r;  yi_nxt = yi_r;  xj_nxt = xj_r;  yj_nxt = yj_r;
    lim_nxt = lim_r;  adx_nxt = adx_r;  ady_nxt = ady_r;
    dyp_nxt = dyp_r;  dxn_nxt = dxn_r;  mx_nxt = mx_r;  my_nxt = my_r;
    dx2_nxt = dx2_r;  dy2_nxt = dy2_r;  d2_nxt = d2_r;  q_nxt = q_r;
    ph_nxt = ph_r;  side_nxt = side_r;  fits_nxt = fits_r;
    ax_nxt = ax_r;  ay_nxt = ay_r;  cx_nxt = cx_r;  cy_nxt = cy_r;
    ex_nxt = ex_r;  ey_nxt = ey_r;  ex2_nxt = ex2_r;
    next_pair = 1'b0;
    k_adv     = 1'b0;
    fail      = 1'b0;
    unique case (state_r)
      SS_IDLE: begin
        if (ereq.start) begin
          n_nxt     = ereq.count;
          state_nxt = SS_LIM;
        end
      end
      SS_LIM: state_nxt = SS_LIMW;
      SS_LIMW: begin
        lim_nxt = mul_p_r;
        k_nxt   = '0;
        if (n_r <= CNT_W'(1)) begin
          fits_nxt  = 1'b1;
          state_nxt = SS_DONE;
        end else begin
          state_nxt = SS_SAME_RD;
        end
      end
      // Check whether every point equals the first one.
      SS_SAME_RD: state_nxt = SS_SAME_CHK;
      SS_SAME_CHK: begin
        if (k_r == '0) begin
          xi_nxt    = px;
          yi_nxt    = py;
          k_nxt     = k_inc[CNT_W-1:0];
          state_nxt = SS_SAME_RD;
        end else if ((px != xi_r) || (py != yi_r)) begin
          i_nxt     = '0;
          j_nxt     = CNT_W'(1);
          state_nxt = SS_PI_RD;
        end else if (k_inc == {1'b0, n_r}) begin
          fits_nxt  = 1'b1;
          state_nxt = SS_DONE;
        end else begin
          k_nxt     = k_inc[CNT_W-1:0];
          state_nxt = SS_SAME_RD;
        end
      end
      // Fetch the pair.
      SS_PI_RD: state_nxt = SS_PJ_RD;
      SS_PJ_RD: begin
        xi_nxt    = px;
        yi_nxt    = py;
        state_nxt = SS_PJ_CAP;
      end
      SS_PJ_CAP: begin
        xj_nxt    = px;
        yj_nxt    = py;
        state_nxt = SS_DIFF;
      end
      SS_DIFF: begin
        if ((adx > {1'b0, two_r}) || (ady > {1'b0, two_r})) begin
          next_pair = 1'b1;
        end else begin
          adx_nxt   = adx[31:0];
          ady_nxt   = ady[31:0];
          dyp_nxt   = !dy[32];
          dxn_nxt   = dx[32] || (dx == '0);
          mx_nxt    = {xi_r[31], xi_r} + {xj_r[31], xj_r};
          my_nxt    = {yi_r[31], yi_r} + {yj_r[31], yj_r};
          state_nxt = SS_SQX;
        end
      end
      SS_SQX: state_nxt = SS_SQY;
      SS_SQY: begin
        dx2_nxt   = mul_p_r;
        state_nxt = SS_D2;
      end
      SS_D2: begin
        dy2_nxt   = mul_p_r;
        state_nxt = SS_CHK;
      end
      // Coincident or too distant pairs define no centre.
      SS_CHK: begin
        if ((d2 == '0) || (d2 > {1'b0, lim_r})) begin
          next_pair = 1'b1;
        end else begin
          d2_nxt    = d2[63:0];
          q_nxt     = lim_r - d2[63:0];
          ph_nxt    = 1'b0;
          state_nxt = SS_ROOT_GO;
        end
      end
      SS_ROOT_GO: state_nxt = SS_ROOT_WAIT;
      SS_ROOT_WAIT: begin
        if (rrsp.done) begin
          if (!ph_r) begin
            ax_nxt    = rrsp.root;
            ph_nxt    = 1'b1;
            state_nxt = SS_ROOT_GO;
          end else begin
            ay_nxt    = rrsp.root;
            side_nxt  = 1'b0;
            state_nxt = SS_CENTRE;
          end
        end
      end
      SS_CENTRE: begin
        cx_nxt    = {mx_r[32], mx_r} + ox;
        cy_nxt    = {my_r[32], my_r} + oy;
        k_nxt     = '0;
        state_nxt = SS_T_RD;
      end
      // Test every other point against the centre.
      SS_T_RD: state_nxt = SS_T_CHK;
      SS_T_CHK: begin
        if (skip) begin
          k_adv = 1'b1;
        end else if ((exm > {4'b0, two_r}) || (eym > {4'b0, two_r})) begin
          fail = 1'b1;
        end else begin
          ex_nxt    = exm[31:0];
          ey_nxt    = eym[31:0];
          state_nxt = SS_T_MX;
        end
      end
      SS_T_MX: state_nxt = SS_T_MY;
      SS_T_MY: begin
        ex2_nxt   = mul_p_r;
        state_nxt = SS_T_SUM;
      end
      SS_T_SUM: begin
        if (s <= {1'b0, lim_r}) begin
          k_adv = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      SS_DONE: state_nxt = SS_IDLE;
      default: state_nxt = SS_IDLE;
    endcase

    // Point passed: next point, or the whole set fits.
    if (k_adv) begin
      if (k_inc == {1'b0, n_r}) begin
        fits_nxt  = 1'b1;
        state_nxt = SS_DONE;
      end else begin
        k_nxt     = k_inc[CNT_W-1:0];
        state_nxt = SS_T_RD;
      end
    end

    // Centre failed: try the other centre, then the next pair.
    if (fail) begin
      if (!side_r) begin
        side_nxt  = 1'b1;
        state_nxt = SS_CENTRE;
      end else begin
        next_pair = 1'b1;
      end
    end

    if (next_pair) begin
      if (last_pair) begin
        fits_nxt  = 1'b0;
        state_nxt = SS_DONE;
      end else begin
        if (wrap) begin
          i_nxt = i_r + 1'b1;
          j_nxt = i_inc2[CNT_W-1:0];
        end else begin
          j_nxt = j_inc[CNT_W-1:0];
        end
        state_nxt = SS_PI_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r <= n_nxt;  i_r <= i_nxt;  j_r <= j_nxt;  k_r <= k_nxt;
    xi_r <= xi_nxt;  yi_r <= yi_nxt;  xj_r <= xj_nxt;  yj_r <= yj_nxt;
    lim_r <= lim_nxt;  adx_r <= adx_nxt;  ady_r <= ady_nxt;
    dyp_r <= dyp_nxt;  dxn_r <= dxn_nxt;  mx_r <= mx_nxt;  my_r <= my_nxt;
    dx2_r <= dx2_nxt;  dy2_r <= dy2_nxt;  d2_r <= d2_nxt;  q_r <= q_nxt;
    ph_r <= ph_nxt;  side_r <= side_nxt;  fits_r <= fits_nxt;
    ax_r <= ax_nxt;  ay_r <= ay_nxt;  cx_r <= cx_nxt;  cy_r <= cy_nxt;
    ex_r <= ex_nxt;  ey_r <= ey_nxt;  ex2_r <= ex2_nxt;
    mul_p_r <= mul_a * mul_b;
  end

  assign rreq.start = (state_r == SS_ROOT_GO);
  assign rreq.a     = ph_r ? dx2_r : dy2_r;
  assign rreq.b     = q_r;
  assign rreq.c     = d2_r;

  assign ersp.done = (state_r == SS_DONE);
  assign ersp.fits = fits_r;

endmodule

@@ design/cef_checker.sv @@
module cef_sva import cef_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_ready,
  input out_item_t        out_data,
  input logic             cfg_we,
  input logic [RAD_W-1:0] cfg_wdata
);

  // A waiting result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The last point of a set stops input while the set is judged.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_point |=> !in_ready)
    else $error("input taken during evaluation");

  // A new result only appears at the end of an evaluation.
  a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without evaluation");

endmodule

bind circle_enclosure_feasibility_top cef_sva u_checker (.*);
